// ===== rtl/pass_pkg.sv =====
// ----------------------------------------------------------------------------
// pass_pkg
// Types and constants shared by the pilot arc start sequencer files.
// ----------------------------------------------------------------------------
package pass_pkg;

  localparam int CNT_W   = 32;
  localparam int DELAY_W = 16;
  localparam int PWM_W   = 16;
  localparam int HIST_W  = 8;
  localparam int CFG_W   = 16;

  localparam logic [HIST_W-1:0] START_MASK = 8'h3f;
  localparam logic [HIST_W-1:0] STOP_MASK  = 8'h0f;

  localparam logic [DELAY_W-1:0] RST_PILOT_ON     = 16'd200;
  localparam logic [DELAY_W-1:0] RST_PILOT_OFF    = 16'd100;
  localparam logic [PWM_W-1:0]   RST_PWM_OFFSET   = 16'd57935;
  localparam logic [DELAY_W-1:0] RST_STARTUP_WAIT = 16'd1000;
  localparam logic [DELAY_W-1:0] RST_IGNITE_TMO   = 16'd5000;
  localparam logic [DELAY_W-1:0] RST_SWITCHOVER   = 16'd100;
  localparam logic [DELAY_W-1:0] RST_PILOT_RUN    = 16'd5000;
  localparam logic [DELAY_W-1:0] RST_SWITCH_SMP   = 16'd10;

  typedef enum logic [2:0] {
    CFG_PILOT_ON     = 3'd0,
    CFG_PILOT_OFF    = 3'd1,
    CFG_PWM_OFFSET   = 3'd2,
    CFG_STARTUP_WAIT = 3'd3,
    CFG_IGNITE_TMO   = 3'd4,
    CFG_SWITCHOVER   = 3'd5,
    CFG_PILOT_RUN    = 3'd6,
    CFG_SWITCH_SMP   = 3'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_STARTUP    = 3'd0,
    PH_WAIT_START = 3'd1,
    PH_IGNITE     = 3'd2,
    PH_FAIL       = 3'd3,
    PH_SWITCHOVER = 3'd4,
    PH_RUNNING    = 3'd5,
    PH_RELEASE    = 3'd6
  } phase_t;

endpackage

// ===== rtl/pass_in_if.sv =====
// ----------------------------------------------------------------------------
// pass_in_if
// Tick channel: one beat per millisecond tick with the converter samples.
// ----------------------------------------------------------------------------
interface pass_in_if #(
  parameter int SAMPLE_WIDTH = 10
);
  logic                    valid;
  logic                    ready;
  logic                    samples_valid;
  logic [SAMPLE_WIDTH-1:0] pilot_sample;
  logic [SAMPLE_WIDTH-1:0] torch_sample;
  logic [SAMPLE_WIDTH-1:0] hall_sample;
  logic                    start_switch;

  modport source (
    output valid, samples_valid, pilot_sample, torch_sample, hall_sample, start_switch,
    input  ready
  );
  modport sink (
    input  valid, samples_valid, pilot_sample, torch_sample, hall_sample, start_switch,
    output ready
  );
endinterface

// ===== rtl/pass_out_if.sv =====
// ----------------------------------------------------------------------------
// pass_out_if
// Result channel: phase, arc enable, PWM compare and filtered levels.
// ----------------------------------------------------------------------------
interface pass_out_if #(
  parameter int SAMPLE_WIDTH = 10
);
  import pass_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [2:0]              phase_code;
  logic                    arc_enable;
  logic [PWM_W-1:0]        pwm_compare;
  logic [SAMPLE_WIDTH-1:0] pilot_level;
  logic [SAMPLE_WIDTH-1:0] torch_level;
  logic [SAMPLE_WIDTH-1:0] hall_level;

  modport source (
    output valid, phase_code, arc_enable, pwm_compare, pilot_level, torch_level, hall_level,
    input  ready
  );
  modport sink (
    input  valid, phase_code, arc_enable, pwm_compare, pilot_level, torch_level, hall_level,
    output ready
  );
endinterface

// ===== rtl/pass_cfg_if.sv =====
// ----------------------------------------------------------------------------
// pass_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface pass_cfg_if;
  import pass_pkg::*;
  logic             valid;
  logic             ready;
  cfg_idx_t         index;
  logic [CFG_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/pilot_arc_start_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// pilot_arc_start_sequencer_core
// Per-tick sample filtering, phase sequencing and switch debounce.
// ----------------------------------------------------------------------------
// Latency: a result is registered and valid in the cycle after its tick beat is accepted.
// Throughput: one tick per cycle; the output register alone sets the rate,
//   a new tick is taken whenever the result register is empty or draining.
// Reset: synchronous, active low; phase returns to startup wait, counter,
//   filters and switch history clear, registers take their default values.
// Configuration writes are taken in every cycle.
module pilot_arc_start_sequencer_core
  import pass_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 10
) (
  input  logic clk,
  input  logic rst_n,
  pass_in_if.sink    in_chan,
  pass_out_if.source out_chan,
  pass_cfg_if.sink   cfg_chan
);

  localparam int W = SAMPLE_WIDTH;

  logic [W-1:0]       pilot_on_r, pilot_off_r;
  logic [PWM_W-1:0]   pwm_offset_r;
  logic [DELAY_W-1:0] startup_wait_r, ignite_tmo_r, switchover_r, pilot_run_r, switch_smp_r;

  logic [CNT_W-1:0]  ms_counter_r, phase_deadline_r, sample_deadline_r;
  logic [CNT_W-1:0]  phase_deadline_nxt, sample_deadline_nxt;
  phase_t            phase_r, phase_nxt;
  logic [HIST_W-1:0] hist_r, hist_nxt;
  logic              arc_on_r, arc_on_nxt;
  logic [W-1:0]      pilot_f_r, torch_f_r, hall_f_r;
  logic [W-1:0]      pilot_f_nxt, torch_f_nxt, hall_f_nxt;

  logic              out_valid_r;
  logic [2:0]        out_phase_r;
  logic              out_arc_r;
  logic [PWM_W-1:0]  out_pwm_r, pwm_nxt;
  logic [W-1:0]      out_pilot_r, out_torch_r, out_hall_r;

  logic              in_fire;
  logic [CNT_W-1:0]  now;
  logic              sample_due, phase_due, do_check;
  logic [HIST_W-1:0] hist_shift;
  logic [W+2:0]      torch_x7;

  function automatic logic [W-1:0] filt_step(input logic [W-1:0] f, input logic [W-1:0] s);
    logic signed [W:0] d;
    logic signed [W:0] q;
    logic signed [W:0] sum;
    d   = $signed({1'b0, s}) - $signed({1'b0, f});
    q   = d >>> 4;
    sum = $signed({1'b0, f}) + q;
    return sum[W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] ext_delay(input logic [DELAY_W-1:0] v);
    return {{(CNT_W-DELAY_W){1'b0}}, v};
  endfunction

  assign in_chan.ready  = !out_valid_r || out_chan.ready;
  assign in_fire        = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pilot_on_r     <= RST_PILOT_ON[W-1:0];
      pilot_off_r    <= RST_PILOT_OFF[W-1:0];
      pwm_offset_r   <= RST_PWM_OFFSET;
      startup_wait_r <= RST_STARTUP_WAIT;
      ignite_tmo_r   <= RST_IGNITE_TMO;
      switchover_r   <= RST_SWITCHOVER;
      pilot_run_r    <= RST_PILOT_RUN;
      switch_smp_r   <= RST_SWITCH_SMP;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        CFG_PILOT_ON:     pilot_on_r     <= cfg_chan.data[W-1:0];
        CFG_PILOT_OFF:    pilot_off_r    <= cfg_chan.data[W-1:0];
        CFG_PWM_OFFSET:   pwm_offset_r   <= cfg_chan.data;
        CFG_STARTUP_WAIT: startup_wait_r <= cfg_chan.data;
        CFG_IGNITE_TMO:   ignite_tmo_r   <= cfg_chan.data;
        CFG_SWITCHOVER:   switchover_r   <= cfg_chan.data;
        CFG_PILOT_RUN:    pilot_run_r    <= cfg_chan.data;
        CFG_SWITCH_SMP:   switch_smp_r   <= cfg_chan.data;
      endcase
    end
  end

  always_comb begin
    pilot_f_nxt = pilot_f_r;
    torch_f_nxt = torch_f_r;
    hall_f_nxt  = hall_f_r;
    if (in_chan.samples_valid) begin
      pilot_f_nxt = filt_step(pilot_f_r, in_chan.pilot_sample);
      torch_f_nxt = filt_step(torch_f_r, in_chan.torch_sample);
      hall_f_nxt  = filt_step(hall_f_r, in_chan.hall_sample);
    end

    now        = ms_counter_r + 32'd1;
    sample_due = now > sample_deadline_r;
    phase_due  = now > phase_deadline_r;
    hist_shift = {hist_r[HIST_W-2:0], in_chan.start_switch};

    phase_nxt           = phase_r;
    arc_on_nxt          = arc_on_r;
    hist_nxt            = hist_r;
    phase_deadline_nxt  = phase_deadline_r;
    sample_deadline_nxt = sample_deadline_r;
    do_check            = 1'b1;

    unique case (phase_r)
      PH_STARTUP: begin
        do_check = phase_due;
      end
      PH_WAIT_START: begin
        do_check = 1'b0;
        if (sample_due) begin
          sample_deadline_nxt = now + ext_delay(switch_smp_r);
          hist_nxt            = hist_shift;
          if ((hist_shift & START_MASK) == START_MASK) begin
            arc_on_nxt         = 1'b1;
            phase_nxt          = PH_IGNITE;
            phase_deadline_nxt = now + ext_delay(ignite_tmo_r);
          end
        end
      end
      PH_IGNITE: begin
        if (phase_due) begin
          phase_nxt  = PH_FAIL;
          arc_on_nxt = 1'b0;
        end
        if (pilot_f_nxt > pilot_on_r) begin
          phase_nxt          = PH_SWITCHOVER;
          phase_deadline_nxt = now + ext_delay(switchover_r);
        end
      end
      PH_SWITCHOVER: begin
        if (phase_due) begin
          phase_nxt          = PH_RUNNING;
          phase_deadline_nxt = now + ext_delay(pilot_run_r);
        end
      end
      PH_RUNNING: begin
        if (phase_due || (pilot_f_nxt < pilot_off_r)) begin
          phase_nxt  = PH_RELEASE;
          arc_on_nxt = 1'b0;
        end
      end
      default: begin
        arc_on_nxt = 1'b0;
      end
    endcase

    if (do_check && sample_due) begin
      sample_deadline_nxt = now + ext_delay(switch_smp_r);
      hist_nxt            = hist_shift;
      if ((hist_shift & STOP_MASK) == '0) begin
        arc_on_nxt = 1'b0;
        phase_nxt  = PH_WAIT_START;
        hist_nxt   = '0;
      end
    end

    torch_x7 = {torch_f_nxt, 3'b000} - {3'b000, torch_f_nxt};
    pwm_nxt  = pwm_offset_r + {{(PWM_W-W-3){1'b0}}, torch_x7};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_counter_r      <= '0;
      phase_r           <= PH_STARTUP;
      phase_deadline_r  <= ext_delay(RST_STARTUP_WAIT);
      sample_deadline_r <= ext_delay(RST_SWITCH_SMP);
      hist_r            <= '0;
      arc_on_r          <= 1'b0;
      pilot_f_r         <= '0;
      torch_f_r         <= '0;
      hall_f_r          <= '0;
    end else if (in_fire) begin
      ms_counter_r      <= now;
      phase_r           <= phase_nxt;
      phase_deadline_r  <= phase_deadline_nxt;
      sample_deadline_r <= sample_deadline_nxt;
      hist_r            <= hist_nxt;
      arc_on_r          <= arc_on_nxt;
      pilot_f_r         <= pilot_f_nxt;
      torch_f_r         <= torch_f_nxt;
      hall_f_r          <= hall_f_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_phase_r <= phase_nxt;
      out_arc_r   <= arc_on_nxt;
      out_pwm_r   <= pwm_nxt;
      out_pilot_r <= pilot_f_nxt;
      out_torch_r <= torch_f_nxt;
      out_hall_r  <= hall_f_nxt;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.phase_code  = out_phase_r;
  assign out_chan.arc_enable  = out_arc_r;
  assign out_chan.pwm_compare = out_pwm_r;
  assign out_chan.pilot_level = out_pilot_r;
  assign out_chan.torch_level = out_torch_r;
  assign out_chan.hall_level  = out_hall_r;

  a_arc_phase: assert property (@(posedge clk) disable iff (!rst_n)
    arc_on_r |-> (phase_r == PH_IGNITE || phase_r == PH_SWITCHOVER || phase_r == PH_RUNNING))
    else $error("arc on outside ignite, switchover or running");

  a_tick_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> ms_counter_r == $past(ms_counter_r) + 32'd1)
    else $error("tick counter did not advance on accepted beat");

  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(phase_r) && $stable(hist_r))
    else $error("sequencer state moved without a tick");

  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r && out_phase_r == phase_r && out_arc_r == arc_on_r)
    else $error("result register does not match sequencer state");

endmodule

// ===== tb/tb_pilot_arc_start_sequencer_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pilot_arc_start_sequencer_core
// Sends millisecond tick beats through the sequencer and works out every
// result beat from a cycle-free model of the filters, phases and switch
// debounce. Each result beat is compared field by field in order.
// Directed beats hit the sample extremes. Random arc start sessions then
// run the debounce, ignition, switchover, running and release paths over
// several register settings. Both channels idle at random, and one long
// output stall backs the block up.
// ----------------------------------------------------------------------------
module tb_pilot_arc_start_sequencer_core;
  import pass_pkg::*;

  localparam int SAMPLE_W    = 10;
  localparam int LEVEL_MAX   = (1 << SAMPLE_W) - 1;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 600000;

  typedef logic [SAMPLE_W-1:0] level_t;

  localparam level_t LVL_TOP  = '1;
  localparam level_t LVL_ZERO = '0;

  typedef struct {
    logic   fresh;
    level_t pilot;
    level_t torch;
    level_t hall;
    logic   sw;
  } tick_t;

  typedef struct {
    phase_t           phase;
    logic             arc;
    logic [PWM_W-1:0] pwm;
    level_t           pilot;
    level_t           torch;
    level_t           hall;
  } status_t;

  logic clk;
  logic rst_n;

  pass_in_if  #(.SAMPLE_WIDTH(SAMPLE_W)) in_if ();
  pass_out_if #(.SAMPLE_WIDTH(SAMPLE_W)) out_if ();
  pass_cfg_if cfg_if ();

  pilot_arc_start_sequencer_core #(.SAMPLE_WIDTH(SAMPLE_W)) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if),
    .cfg_chan(cfg_if)
  );

  // sequencer model state
  logic [CNT_W-1:0]  tick_count;
  logic [CNT_W-1:0]  phase_due;
  logic [CNT_W-1:0]  sample_due;
  phase_t            cur_phase;
  logic [HIST_W-1:0] sw_hist;
  level_t            pilot_f;
  level_t            torch_f;
  level_t            hall_f;
  logic              arc_flag;

  // register copies
  level_t             on_lvl;
  level_t             off_lvl;
  logic [PWM_W-1:0]   pwm_base;
  logic [DELAY_W-1:0] startup_dly;
  logic [DELAY_W-1:0] ignite_dly;
  logic [DELAY_W-1:0] switchover_dly;
  logic [DELAY_W-1:0] run_dly;
  logic [DELAY_W-1:0] sample_dly;

  status_t expected_status[$];
  int      error_count = 0;
  int      cycle_count = 0;
  bit      src_gaps = 1'b1;
  bit      sink_gaps = 1'b1;
  bit      hold_request = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic level_t smooth(level_t f, level_t s);
    int d;
    d = int'(s) - int'(f);
    return level_t'(int'(f) + (d >>> 4));
  endfunction

  function automatic void model_reset();
    on_lvl         = level_t'(RST_PILOT_ON);
    off_lvl        = level_t'(RST_PILOT_OFF);
    pwm_base       = RST_PWM_OFFSET;
    startup_dly    = RST_STARTUP_WAIT;
    ignite_dly     = RST_IGNITE_TMO;
    switchover_dly = RST_SWITCHOVER;
    run_dly        = RST_PILOT_RUN;
    sample_dly     = RST_SWITCH_SMP;
    tick_count     = '0;
    cur_phase      = PH_STARTUP;
    phase_due      = CNT_W'(startup_dly);
    sample_due     = CNT_W'(sample_dly);
    sw_hist        = '0;
    pilot_f        = '0;
    torch_f        = '0;
    hall_f         = '0;
    arc_flag       = 1'b0;
  endfunction

  function automatic void apply_register(cfg_idx_t idx, logic [CFG_W-1:0] value);
    case (idx)
      CFG_PILOT_ON:     on_lvl = level_t'(value);
      CFG_PILOT_OFF:    off_lvl = level_t'(value);
      CFG_PWM_OFFSET:   pwm_base = value;
      CFG_STARTUP_WAIT: startup_dly = value;
      CFG_IGNITE_TMO:   ignite_dly = value;
      CFG_SWITCHOVER:   switchover_dly = value;
      CFG_PILOT_RUN:    run_dly = value;
      CFG_SWITCH_SMP:   sample_dly = value;
      default: ;
    endcase
  endfunction

  // sample the switch each interval; four lows drop back to waiting
  function automatic void debounce_stop(logic sw);
    if (tick_count > sample_due) begin
      sample_due = tick_count + CNT_W'(sample_dly);
      sw_hist = {sw_hist[HIST_W-2:0], sw};
      if ((sw_hist & STOP_MASK) == '0) begin
        arc_flag  = 1'b0;
        cur_phase = PH_WAIT_START;
        sw_hist   = '0;
      end
    end
  endfunction

  function automatic status_t advance_tick(tick_t t);
    status_t r;
    if (t.fresh) begin
      pilot_f = smooth(pilot_f, t.pilot);
      torch_f = smooth(torch_f, t.torch);
      hall_f  = smooth(hall_f, t.hall);
    end
    tick_count = tick_count + CNT_W'(1);
    case (cur_phase)
      PH_STARTUP: begin
        if (tick_count > phase_due) debounce_stop(t.sw);
      end
      PH_WAIT_START: begin
        if (tick_count > sample_due) begin
          sample_due = tick_count + CNT_W'(sample_dly);
          sw_hist = {sw_hist[HIST_W-2:0], t.sw};
          if ((sw_hist & START_MASK) == START_MASK) begin
            arc_flag  = 1'b1;
            cur_phase = PH_IGNITE;
            phase_due = tick_count + CNT_W'(ignite_dly);
          end
        end
      end
      PH_IGNITE: begin
        if (tick_count > phase_due) begin
          cur_phase = PH_FAIL;
          arc_flag  = 1'b0;
        end
        if (pilot_f > on_lvl) begin
          cur_phase = PH_SWITCHOVER;
          phase_due = tick_count + CNT_W'(switchover_dly);
        end
        debounce_stop(t.sw);
      end
      PH_SWITCHOVER: begin
        if (tick_count > phase_due) begin
          cur_phase = PH_RUNNING;
          phase_due = tick_count + CNT_W'(run_dly);
        end
        debounce_stop(t.sw);
      end
      PH_RUNNING: begin
        if (tick_count > phase_due || pilot_f < off_lvl) begin
          cur_phase = PH_RELEASE;
          arc_flag  = 1'b0;
        end
        debounce_stop(t.sw);
      end
      default: begin
        arc_flag = 1'b0;
        debounce_stop(t.sw);
      end
    endcase
    r.phase = cur_phase;
    r.arc   = arc_flag;
    r.pwm   = pwm_base + PWM_W'(32'd7 * 32'(torch_f));
    r.pilot = pilot_f;
    r.torch = torch_f;
    r.hall  = hall_f;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    error_count++;
    $display("%0t mismatch on %s: got %0d, want %0d", $time, what, got, want);
  endtask

  initial model_reset();

  always @(posedge clk) begin
    status_t want;
    tick_t   seen;
    if (!rst_n) begin
      model_reset();
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_status.size() == 0) begin
          report_mismatch("result beat with none pending", 1, 0);
        end else begin
          want = expected_status.pop_front();
          if (out_if.phase_code !== want.phase)
            report_mismatch("phase_code", out_if.phase_code, want.phase);
          if (out_if.arc_enable !== want.arc)
            report_mismatch("arc_enable", out_if.arc_enable, want.arc);
          if (out_if.pwm_compare !== want.pwm)
            report_mismatch("pwm_compare", out_if.pwm_compare, want.pwm);
          if (out_if.pilot_level !== want.pilot)
            report_mismatch("pilot_level", out_if.pilot_level, want.pilot);
          if (out_if.torch_level !== want.torch)
            report_mismatch("torch_level", out_if.torch_level, want.torch);
          if (out_if.hall_level !== want.hall)
            report_mismatch("hall_level", out_if.hall_level, want.hall);
        end
      end
      if (cfg_if.valid && cfg_if.ready) apply_register(cfg_if.index, cfg_if.data);
      if (in_if.valid && in_if.ready) begin
        seen.fresh = in_if.samples_valid;
        seen.pilot = in_if.pilot_sample;
        seen.torch = in_if.torch_sample;
        seen.hall  = in_if.hall_sample;
        seen.sw    = in_if.start_switch;
        expected_status.push_back(advance_tick(seen));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_pilot_arc_start_sequencer_core: errors");
      $finish;
    end
  end

  // result side: random stall bursts, plus one long hold on request
  initial begin
    int hold_left;
    int stall_left;
    hold_left  = 0;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (sink_gaps && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 18);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  function automatic bit jitter(bit level);
    return level ^ ($urandom_range(0, 19) == 0);
  endfunction

  function automatic tick_t make_tick(bit sw, int unsigned lo, int unsigned hi);
    tick_t t;
    t.fresh = ($urandom_range(0, 9) != 0);
    t.pilot = level_t'(t.fresh ? $urandom_range(lo, hi) : $urandom_range(0, LEVEL_MAX));
    t.torch = level_t'($urandom_range(0, LEVEL_MAX));
    t.hall  = level_t'($urandom_range(0, LEVEL_MAX));
    t.sw    = sw;
    return t;
  endfunction

  task automatic send_tick(tick_t t);
    if (src_gaps && $urandom_range(0, 7) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.samples_valid <= t.fresh;
    in_if.pilot_sample  <= t.pilot;
    in_if.torch_sample  <= t.torch;
    in_if.hall_sample   <= t.hall;
    in_if.start_switch  <= t.sw;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_idx_t idx, logic [CFG_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk);
    while (cfg_if.ready !== 1'b1) @(posedge clk);
  endtask

  task automatic apply_settings(logic [CFG_W-1:0] on, logic [CFG_W-1:0] off,
                                logic [CFG_W-1:0] pwm, logic [CFG_W-1:0] startup,
                                logic [CFG_W-1:0] ignite, logic [CFG_W-1:0] switchover,
                                logic [CFG_W-1:0] run, logic [CFG_W-1:0] smp);
    wait_drained();
    cfg_write(CFG_PILOT_ON, on);
    cfg_write(CFG_PILOT_OFF, off);
    cfg_write(CFG_PWM_OFFSET, pwm);
    cfg_write(CFG_STARTUP_WAIT, startup);
    cfg_write(CFG_IGNITE_TMO, ignite);
    cfg_write(CFG_SWITCHOVER, switchover);
    cfg_write(CFG_PILOT_RUN, run);
    cfg_write(CFG_SWITCH_SMP, smp);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic random_settings();
    apply_settings({6'($urandom), 10'($urandom_range(100, 700))},
                   {6'($urandom), 10'($urandom_range(0, 150))},
                   16'($urandom), 16'($urandom),
                   16'($urandom_range(0, 120)), 16'($urandom_range(0, 40)),
                   16'($urandom_range(0, 150)), 16'($urandom_range(0, 4)));
  endtask

  // low switch, then a held switch with low, high and falling pilot current; at random, mixed ticks instead
  task automatic run_session();
    int span;
    span = int'(sample_dly) + 1;
    if ($urandom_range(0, 6) == 0) begin
      repeat (40) send_tick(make_tick(1'($urandom_range(0, 1)), 0, LEVEL_MAX));
    end else begin
      repeat (5 * span + $urandom_range(0, 20)) send_tick(make_tick(jitter(1'b0), 0, 60));
      repeat ($urandom_range(0, 8 * span)) send_tick(make_tick(jitter(1'b1), 0, 60));
      repeat ($urandom_range(5, 80)) send_tick(make_tick(jitter(1'b1), 500, LEVEL_MAX));
      repeat ($urandom_range(0, 60)) send_tick(make_tick(jitter(1'b1), 0, 60));
    end
  endtask

  task automatic test_filter_extremes();
    repeat (6) send_tick(tick_t'{1'b1, LVL_TOP, LVL_TOP, LVL_TOP, 1'b1});
    send_tick(tick_t'{1'b0, LVL_ZERO, LVL_ZERO, LVL_ZERO, 1'b0});
    send_tick(tick_t'{1'b0, LVL_TOP, LVL_TOP, LVL_TOP, 1'b1});
    repeat (6) send_tick(tick_t'{1'b1, LVL_ZERO, LVL_ZERO, LVL_ZERO, 1'b0});
    send_tick(tick_t'{1'b1, LVL_TOP, LVL_ZERO, LVL_TOP, 1'b1});
    send_tick(tick_t'{1'b1, LVL_ZERO, LVL_TOP, LVL_ZERO, 1'b0});
    send_tick(tick_t'{1'b1, level_t'(15), level_t'(16), level_t'(17), 1'b1});
  endtask

  // startup deadline was set at reset and must survive the new wait value
  task automatic test_startup_release();
    apply_settings(16'd300, 16'd80, 16'h0000, 16'hFFFF, 16'd60, 16'd5, 16'd80, 16'd1);
    repeat (990) send_tick(make_tick(1'($urandom_range(0, 1)), 0, LEVEL_MAX));
    repeat (20) send_tick(make_tick(1'b0, 0, 60));
  endtask

  task automatic test_arc_sessions(int count);
    repeat (count) run_session();
  endtask

  // zero ignite timeout with pilot already above a zero threshold
  task automatic test_timeout_with_ignition();
    apply_settings(16'h0000, 16'h03FF, 16'hFFFF, 16'h0000,
                   16'h0000, 16'h0000, 16'h0000, 16'h0000);
    repeat (12) send_tick(make_tick(1'b0, 200, LEVEL_MAX));
    repeat (30) send_tick(make_tick(1'b1, 200, LEVEL_MAX));
    repeat (10) send_tick(make_tick(1'b0, 200, LEVEL_MAX));
  endtask

  task automatic test_output_backpressure();
    src_gaps     = 1'b0;
    hold_request = 1'b1;
    repeat (40) send_tick(make_tick(jitter(1'b1), 0, LEVEL_MAX));
    src_gaps = 1'b1;
  endtask

  initial begin
    rst_n               <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.samples_valid <= 1'b0;
    in_if.pilot_sample  <= '0;
    in_if.torch_sample  <= '0;
    in_if.hall_sample   <= '0;
    in_if.start_switch  <= 1'b0;
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= CFG_PILOT_ON;
    cfg_if.data         <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_filter_extremes();
    test_startup_release();
    test_arc_sessions(5);
    apply_settings(16'hFFFF, 16'hFC00, 16'hFFFF, 16'h0000,
                   16'd30, 16'h0000, 16'hFFFF, 16'd3);
    test_arc_sessions(2);
    apply_settings(16'h0100, 16'hFC00, 16'h8000, 16'h0000,
                   16'hFFFF, 16'd3, 16'hFFFF, 16'd2);
    test_arc_sessions(2);
    test_timeout_with_ignition();
    repeat (3) begin
      random_settings();
      test_arc_sessions(2);
    end
    test_output_backpressure();

    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    random_settings();
    test_arc_sessions(2);

    wait_drained();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_pilot_arc_start_sequencer_core: clean");
    end else begin
      $display("tb_pilot_arc_start_sequencer_core: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pass_pkg.sv
rtl/pass_in_if.sv
rtl/pass_out_if.sv
rtl/pass_cfg_if.sv
rtl/pilot_arc_start_sequencer_core.sv
tb/tb_pilot_arc_start_sequencer_core.sv
